### design/etfp_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the escape-time fractal pixel core.
package etfp_pkg;

   localparam int COORD_BITS  = 12;
   localparam int FRAC_BITS   = 28;
   localparam int Q_W         = 32;
   localparam int PROD_W      = 2 * Q_W;
   localparam int SQ_W        = PROD_W - FRAC_BITS;
   localparam int XY_W        = SQ_W + 1;
   localparam int SAT_W       = 48;
   localparam int CNT_W       = 16;
   localparam int COLOR_W     = 32;
   localparam int ENTRY_IDX_W = 4;
   localparam int PSIZE_W     = 5;

   // Bit positions inside the item words.
   localparam int REQ_X_LSB     = 0;
   localparam int REQ_Y_LSB     = REQ_X_LSB + COORD_BITS;
   localparam int REQ_IDX_LSB   = REQ_Y_LSB + COORD_BITS;
   localparam int REQ_COLOR_LSB = REQ_IDX_LSB + ENTRY_IDX_W;
   localparam int REQ_USED_W    = REQ_COLOR_LSB + COLOR_W;
   localparam int REQ_TDATA_W   = ((REQ_USED_W + 7) / 8) * 8;

   localparam int RSP_ESC_BIT   = 2 * COORD_BITS;
   localparam int RSP_CNT_LSB   = RSP_ESC_BIT + 1;
   localparam int RSP_COLOR_LSB = RSP_CNT_LSB + CNT_W;
   localparam int RSP_USED_W    = RSP_COLOR_LSB + COLOR_W;
   localparam int RSP_TDATA_W   = ((RSP_USED_W + 7) / 8) * 8;
   localparam int RSP_PAD_W     = RSP_TDATA_W - RSP_USED_W;

   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 32;

   typedef logic signed [Q_W-1:0]   q_type;
   typedef logic signed [SAT_W-1:0] wide_type;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_SET_MODE  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RE_ORIGIN = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IM_ORIGIN = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RE_STEP   = 4'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_IM_STEP   = 4'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ITER  = 4'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_PAL_SIZE  = 4'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_MONO      = 4'd7;

   // Item kinds carried in req_tuser.
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_PIXEL = 1'b1;

   localparam logic SET_MANDELBROT = 1'b0;

   // Julia constant -0.7 + 0.27015i, rounded to nearest.
   localparam q_type JULIA_RE =
      Q_W'(-(((64'sd7 <<< (FRAC_BITS - 1)) + 64'sd2) / 64'sd5));
   localparam q_type JULIA_IM =
      Q_W'(((64'sd5403 <<< (FRAC_BITS - 5)) + 64'sd312) / 64'sd625);

   localparam logic signed [SQ_W:0] ESC_LIMIT = (SQ_W + 1)'(64'sd4 <<< FRAC_BITS);

   localparam logic [CNT_W-1:0]   MAX_ITER_RST = 16'd256;
   localparam logic [COLOR_W-1:0] MONO_RST     = 32'h00FF_FFFF;

   function automatic q_type sat_q(input wide_type v);
      wide_type hi;
      wide_type lo;
      hi = SAT_W'(64'sd2147483647);
      lo = SAT_W'(-64'sd2147483648);
      if (v > hi) begin
         return Q_W'(hi);
      end else if (v < lo) begin
         return Q_W'(lo);
      end
      return Q_W'(v);
   endfunction

endpackage

### design/etfp_mul.sv
`timescale 1ns / 1ps
// Shared signed 32x32 multiplier with a registered 64-bit product.
module etfp_mul (
   input  logic                                     clock,
   input  etfp_pkg::q_type                          op_a,
   input  etfp_pkg::q_type                          op_b,
   output logic signed [etfp_pkg::PROD_W-1:0]       prod_ff
);

   logic signed [etfp_pkg::PROD_W-1:0] prod_in;

   always_comb begin
      prod_in = etfp_pkg::PROD_W'(op_a) * etfp_pkg::PROD_W'(op_b);
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

### design/escape_time_fractal_pixel_core.sv
`timescale 1ns / 1ps
// Escape-time fractal pixel core: top level with sequencer, palette and result register.
//
// A palette write item is taken while the core stays idle. A pixel item maps (x, y) to a complex
// point and iterates z = z*z + c in signed Q4.28 on one shared 32x32 multiplier, which
// is used three times per iteration (re*re, im*im, re*im) followed by an update step.
// A pixel item keeps req_tready low through two mapping multiplies, the start, the
// iterations, the final escape test (through all three products when it escapes, the
// count check alone when it reaches the limit), the palette read and the hand-off to
// the result register; a result still waiting in the result register lengthens the
// hand-off. The result register lets the next item be taken while a result still waits.
// Palette entries must be written before a pixel can select them.
module escape_time_fractal_pixel_core #(
   parameter int PALETTE_DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // Input items.
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // tdata from bit 0: pixel_x, pixel_y, entry_index, entry_color, zero fill
   input  logic [etfp_pkg::REQ_TDATA_W-1:0]      req_tdata,
   // tuser: op
   input  logic                                  req_tuser,
   // Result items.
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // tdata from bit 0: out_x, out_y, escaped, iterations, color, zero fill
   output logic [etfp_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   // Configuration writes.
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [etfp_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [etfp_pkg::CSR_DATA_W-1:0]       csr_data
);

   localparam int IDX_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
   localparam int SZ_W  = $clog2(PALETTE_DEPTH + 1);
   localparam int CMP_W = (SZ_W > etfp_pkg::PSIZE_W) ? SZ_W : etfp_pkg::PSIZE_W;
   localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(PALETTE_DEPTH);

   localparam int ST_W = 4;
   localparam logic [ST_W-1:0] S_IDLE = 4'd0;
   localparam logic [ST_W-1:0] S_MRE  = 4'd1;
   localparam logic [ST_W-1:0] S_MIM  = 4'd2;
   localparam logic [ST_W-1:0] S_INIT = 4'd3;
   localparam logic [ST_W-1:0] S_RR   = 4'd4;
   localparam logic [ST_W-1:0] S_II   = 4'd5;
   localparam logic [ST_W-1:0] S_RI   = 4'd6;
   localparam logic [ST_W-1:0] S_UPD  = 4'd7;
   localparam logic [ST_W-1:0] S_RD   = 4'd8;
   localparam logic [ST_W-1:0] S_OUT  = 4'd9;

   // Configuration registers.
   logic                                  set_mode_ff;
   etfp_pkg::q_type                       re_origin_ff;
   etfp_pkg::q_type                       im_origin_ff;
   logic [etfp_pkg::Q_W-2:0]              re_step_ff;
   logic [etfp_pkg::Q_W-2:0]              im_step_ff;
   logic [etfp_pkg::CNT_W-1:0]            max_iter_ff;
   logic [etfp_pkg::PSIZE_W-1:0]          pal_size_ff;
   logic [etfp_pkg::COLOR_W-1:0]          mono_ff;

   // Sequencer and datapath registers.
   logic [ST_W-1:0]                       state_ff, state_in;
   logic [etfp_pkg::COORD_BITS-1:0]       px_ff, px_in;
   logic [etfp_pkg::COORD_BITS-1:0]       py_ff, py_in;
   etfp_pkg::q_type                       pre_ff, pre_in;
   etfp_pkg::q_type                       zr_ff, zr_in;
   etfp_pkg::q_type                       zi_ff, zi_in;
   etfp_pkg::q_type                       kr_ff, kr_in;
   etfp_pkg::q_type                       ki_ff, ki_in;
   logic signed [etfp_pkg::SQ_W-1:0]      r2_ff, r2_in;
   logic signed [etfp_pkg::SQ_W-1:0]      i2_ff, i2_in;
   logic [etfp_pkg::CNT_W-1:0]            count_ff, count_in;
   logic [IDX_W-1:0]                      pidx_ff, pidx_in;
   logic                                  esc_ff, esc_in;
   logic [etfp_pkg::COLOR_W-1:0]          rd_ff;
   logic                                  rsp_tvalid_ff, rsp_tvalid_in;
   logic [etfp_pkg::RSP_TDATA_W-1:0]      rsp_tdata_ff, rsp_tdata_in;

   logic [etfp_pkg::COLOR_W-1:0]          palette_mem [0:PALETTE_DEPTH-1];

   // Multiplier interface.
   etfp_pkg::q_type                       mul_a;
   etfp_pkg::q_type                       mul_b;
   logic signed [etfp_pkg::PROD_W-1:0]    prod_ff;

   logic                                  req_fire;
   logic                                  csr_fire;
   logic                                  pal_we;
   logic [IDX_W-1:0]                      wr_addr;
   logic [etfp_pkg::ENTRY_IDX_W-1:0]      req_entry_index;
   logic [etfp_pkg::COLOR_W-1:0]          req_entry_color;
   logic [CMP_W-1:0]                      size_eff;
   logic signed [etfp_pkg::SQ_W-1:0]      sq_now;
   logic signed [etfp_pkg::XY_W-1:0]      xy_now;
   logic signed [etfp_pkg::SQ_W:0]        esc_sum;
   etfp_pkg::q_type                       map_now;
   logic                                  out_free;
   logic [etfp_pkg::COLOR_W-1:0]          color_sel;

   etfp_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .prod_ff (prod_ff)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   assign req_fire = req_tvalid && req_tready;
   assign csr_fire = csr_valid && csr_ready;

   assign req_entry_index = req_tdata[etfp_pkg::REQ_IDX_LSB +: etfp_pkg::ENTRY_IDX_W];
   assign req_entry_color = req_tdata[etfp_pkg::REQ_COLOR_LSB +: etfp_pkg::COLOR_W];
   assign wr_addr = IDX_W'(req_entry_index);
   // Writes to an entry beyond the palette are dropped.
   assign pal_we = req_fire && (req_tuser == etfp_pkg::OP_WRITE)
                   && (CMP_W'(req_entry_index) < DEPTH_C);

   assign size_eff = (CMP_W'(pal_size_ff) > DEPTH_C) ? DEPTH_C : CMP_W'(pal_size_ff);

   // Floored views of the product register.
   assign sq_now  = $signed(prod_ff[etfp_pkg::PROD_W-1:etfp_pkg::FRAC_BITS]);
   assign xy_now  = $signed(prod_ff[etfp_pkg::PROD_W-1:etfp_pkg::FRAC_BITS-1]);
   assign esc_sum = (etfp_pkg::SQ_W + 1)'(r2_ff) + (etfp_pkg::SQ_W + 1)'(sq_now);

   always_comb begin
      map_now = '0;
      if (state_ff == S_MIM) begin
         map_now = etfp_pkg::sat_q(etfp_pkg::SAT_W'(re_origin_ff)
                   + $signed(prod_ff[etfp_pkg::SAT_W-1:0]));
      end else begin
         map_now = etfp_pkg::sat_q(etfp_pkg::SAT_W'(im_origin_ff)
                   + $signed(prod_ff[etfp_pkg::SAT_W-1:0]));
      end
   end

   always_comb begin
      mul_a = zr_ff;
      mul_b = zr_ff;
      case (state_ff)
         S_MRE: begin
            mul_a = etfp_pkg::Q_W'(px_ff);
            mul_b = etfp_pkg::Q_W'(re_step_ff);
         end
         S_MIM: begin
            mul_a = etfp_pkg::Q_W'(py_ff);
            mul_b = etfp_pkg::Q_W'(im_step_ff);
         end
         S_II: begin
            mul_a = zi_ff;
            mul_b = zi_ff;
         end
         S_RI: begin
            mul_a = zr_ff;
            mul_b = zi_ff;
         end
         default: begin
            mul_a = zr_ff;
            mul_b = zr_ff;
         end
      endcase
   end

   assign out_free  = !rsp_tvalid_ff || rsp_tready;
   assign color_sel = !esc_ff ? '0 : ((size_eff == '0) ? mono_ff : rd_ff);

   always_comb begin
      state_in      = state_ff;
      px_in         = px_ff;
      py_in         = py_ff;
      pre_in        = pre_ff;
      zr_in         = zr_ff;
      zi_in         = zi_ff;
      kr_in         = kr_ff;
      ki_in         = ki_ff;
      r2_in         = r2_ff;
      i2_in         = i2_ff;
      count_in      = count_ff;
      pidx_in       = pidx_ff;
      esc_in        = esc_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire && (req_tuser == etfp_pkg::OP_PIXEL)) begin
               px_in    = req_tdata[etfp_pkg::REQ_X_LSB +: etfp_pkg::COORD_BITS];
               py_in    = req_tdata[etfp_pkg::REQ_Y_LSB +: etfp_pkg::COORD_BITS];
               state_in = S_MRE;
            end
         end
         S_MRE: begin
            state_in = S_MIM;
         end
         S_MIM: begin
            pre_in   = map_now;
            state_in = S_INIT;
         end
         S_INIT: begin
            if (set_mode_ff == etfp_pkg::SET_MANDELBROT) begin
               zr_in = '0;
               zi_in = '0;
               kr_in = pre_ff;
               ki_in = map_now;
            end else begin
               zr_in = pre_ff;
               zi_in = map_now;
               kr_in = etfp_pkg::JULIA_RE;
               ki_in = etfp_pkg::JULIA_IM;
            end
            count_in = '0;
            pidx_in  = '0;
            state_in = S_RR;
         end
         S_RR: begin
            if (count_ff >= max_iter_ff) begin
               esc_in   = 1'b0;
               state_in = S_RD;
            end else begin
               state_in = S_II;
            end
         end
         S_II: begin
            r2_in    = sq_now;
            state_in = S_RI;
         end
         S_RI: begin
            i2_in = sq_now;
            if (esc_sum >= etfp_pkg::ESC_LIMIT) begin
               esc_in   = 1'b1;
               state_in = S_RD;
            end else begin
               state_in = S_UPD;
            end
         end
         S_UPD: begin
            zr_in = etfp_pkg::sat_q(etfp_pkg::SAT_W'(r2_ff) - etfp_pkg::SAT_W'(i2_ff)
                    + etfp_pkg::SAT_W'(kr_ff));
            zi_in = etfp_pkg::sat_q(etfp_pkg::SAT_W'(xy_now) + etfp_pkg::SAT_W'(ki_ff));
            count_in = count_ff + 1'b1;
            // Running palette index tracks the count modulo the palette size.
            if ((CMP_W'(pidx_ff) + 1'b1) >= size_eff) begin
               pidx_in = '0;
            end else begin
               pidx_in = pidx_ff + 1'b1;
            end
            state_in = S_RR;
         end
         S_RD: begin
            state_in = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {{etfp_pkg::RSP_PAD_W{1'b0}}, color_sel, count_ff,
                                esc_ff, py_ff, px_ff};
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      px_ff        <= px_in;
      py_ff        <= py_in;
      pre_ff       <= pre_in;
      zr_ff        <= zr_in;
      zi_ff        <= zi_in;
      kr_ff        <= kr_in;
      ki_ff        <= ki_in;
      r2_ff        <= r2_in;
      i2_ff        <= i2_in;
      count_ff     <= count_in;
      pidx_ff      <= pidx_in;
      esc_ff       <= esc_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   always_ff @(posedge clock) begin
      if (pal_we) begin
         palette_mem[wr_addr] <= req_entry_color;
      end
      if (state_ff == S_RD) begin
         rd_ff <= palette_mem[pidx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         set_mode_ff  <= 1'b0;
         re_origin_ff <= '0;
         im_origin_ff <= '0;
         re_step_ff   <= '0;
         im_step_ff   <= '0;
         max_iter_ff  <= etfp_pkg::MAX_ITER_RST;
         pal_size_ff  <= '0;
         mono_ff      <= etfp_pkg::MONO_RST;
      end else if (csr_fire) begin
         unique case (csr_index)
            etfp_pkg::CSR_SET_MODE:  set_mode_ff  <= csr_data[0];
            etfp_pkg::CSR_RE_ORIGIN: re_origin_ff <= $signed(csr_data);
            etfp_pkg::CSR_IM_ORIGIN: im_origin_ff <= $signed(csr_data);
            etfp_pkg::CSR_RE_STEP:   re_step_ff   <= csr_data[etfp_pkg::Q_W-2:0];
            etfp_pkg::CSR_IM_STEP:   im_step_ff   <= csr_data[etfp_pkg::Q_W-2:0];
            etfp_pkg::CSR_MAX_ITER:  max_iter_ff  <= csr_data[etfp_pkg::CNT_W-1:0];
            etfp_pkg::CSR_PAL_SIZE:  pal_size_ff  <= csr_data[etfp_pkg::PSIZE_W-1:0];
            etfp_pkg::CSR_MONO:      mono_ff      <= csr_data;
            default: begin
            end
         endcase
      end
   end

endmodule

### design/etfp_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the escape-time fractal pixel core, bound to the top level.
module etfp_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic                                req_tuser,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [etfp_pkg::RSP_TDATA_W-1:0]    rsp_tdata
);

   // A stalled result item holds its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result item changed while stalled");

   // A point inside the set carries no color.
   a_inside_black: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[etfp_pkg::RSP_ESC_BIT]
      |-> rsp_tdata[etfp_pkg::RSP_COLOR_LSB +: etfp_pkg::COLOR_W] == '0)
      else $error("color set on a point inside the set");

   // A palette write leaves the core ready for the next item.
   a_write_one_cycle: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == etfp_pkg::OP_WRITE) |=> req_tready)
      else $error("core busy after a palette write");

   // A pixel item leaves the core busy once it is taken.
   a_pixel_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == etfp_pkg::OP_PIXEL) |=> !req_tready)
      else $error("core ready right after taking a pixel");

   // Nothing is presented straight out of reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind escape_time_fractal_pixel_core etfp_checker u_etfp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
